// ----- rtl/core/cascading_prescaled_timers_unit_assert.svh -----
// Assertion macros for the cascade timer unit.
`ifndef CASCADING_PRESCALED_TIMERS_UNIT_ASSERT_SVH
`define CASCADING_PRESCALED_TIMERS_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define CPT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cascade timer assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define CPT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cascade timer assertion failed");

`endif

// ----- rtl/core/cpt_pkg.sv -----
// Types, codes and helpers shared by the cascade timer unit.
`default_nettype none
package cpt_pkg;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2
  } cpt_kind_e;

  typedef enum logic [1:0] {
    PRESC_DIV1    = 2'd0,
    PRESC_DIV64   = 2'd1,
    PRESC_DIV256  = 2'd2,
    PRESC_DIV1024 = 2'd3
  } cpt_presc_e;

  localparam logic [15:0] CTL_WRITE_MASK = 16'h00C7;
  localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

  typedef struct packed {
    logic       start;
    logic       irq_en;
    logic       cascade;
    cpt_presc_e presc;
  } cpt_ctrl_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  reg_index;
    logic [15:0] write_data;
  } cpt_in_t;

  typedef struct packed {
    logic [3:0]  irq_pulse;
    logic [3:0]  overflow_pulse;
    logic [15:0] read_data;
  } cpt_out_t;

  function automatic logic [10:0] cpt_divisor(cpt_presc_e sel);
    logic [10:0] div;
    case (sel)
      PRESC_DIV1:    div = 11'd1;
      PRESC_DIV64:   div = 11'd64;
      PRESC_DIV256:  div = 11'd256;
      PRESC_DIV1024: div = 11'd1024;
      default:       div = 11'd1;
    endcase
    return div;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/cpt_chan_if.sv -----
// Valid/ready channel carrying one payload per transaction.
`default_nettype none
interface cpt_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/cascading_prescaled_timers_unit.sv -----
// Four-channel cascading prescaled timer unit: top level.
// Each transaction goes through the input register and then the result register.
// Throughput: one transaction per cycle while the result side is ready; the critical path
// is the overflow carry rippling through the chained 16-bit counters inside the tick update.
// Reset (rst_ni low, asynchronous): all counters, reloads, prescalers and controls
// clear to zero, every timer stopped, both pipeline registers empty.
`default_nettype none
module cascading_prescaled_timers_unit
  import cpt_pkg::*;
#(
  parameter int NUM_TIMERS = 4
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  cpt_chan_if.sink   in_i,
  cpt_chan_if.source out_o
);

  // Pipeline control
  logic     in_valid_q;
  cpt_in_t  in_q;
  logic     out_valid_q;
  cpt_out_t out_q;
  logic     advance;
  logic     in_ready;

  // Timer state
  logic [15:0] reload_q [NUM_TIMERS];
  logic [15:0] reload_d [NUM_TIMERS];
  logic [15:0] live_q   [NUM_TIMERS];
  logic [15:0] live_d   [NUM_TIMERS];
  logic [9:0]  presc_q  [NUM_TIMERS];
  logic [9:0]  presc_d  [NUM_TIMERS];
  cpt_ctrl_t   ctrl_q   [NUM_TIMERS];
  cpt_ctrl_t   ctrl_d   [NUM_TIMERS];

  cpt_out_t    result;
  logic [1:0]  tsel;
  logic [15:0] wmask;

  // The item in the input register moves on whenever the result register is
  // free or being drained this cycle.
  assign advance  = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready = !in_valid_q || advance;

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  assign tsel  = in_q.reg_index[2:1];
  assign wmask = in_q.write_data & CTL_WRITE_MASK;

  // Single-pass update of all timers for the registered item.
  always_comb begin
    logic        carry;
    logic        inc;
    logic [10:0] pc;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      reload_d[i] = reload_q[i];
      live_d[i]   = live_q[i];
      presc_d[i]  = presc_q[i];
      ctrl_d[i]   = ctrl_q[i];
    end
    result = '0;
    carry  = 1'b0;
    inc    = 1'b0;
    pc     = '0;
    case (in_q.kind)
      KIND_TICK: begin
        // Free-running timers step on their prescaler; chained timers step
        // on the overflow of the timer below. Timer 0 never chains.
        for (int i = 0; i < NUM_TIMERS; i++) begin
          inc = 1'b0;
          pc  = {1'b0, presc_q[i]} + 11'd1;
          if (ctrl_q[i].start && !((i > 0) && ctrl_q[i].cascade)) begin
            if (pc >= cpt_divisor(ctrl_q[i].presc)) begin
              presc_d[i] = '0;
              inc        = 1'b1;
            end else begin
              presc_d[i] = pc[9:0];
            end
          end else if (ctrl_q[i].start) begin
            inc = carry;
          end
          carry = 1'b0;
          if (inc) begin
            if (live_q[i] == COUNT_MAX) begin
              live_d[i]                = reload_q[i];
              result.overflow_pulse[i] = 1'b1;
              result.irq_pulse[i]      = ctrl_q[i].irq_en;
              carry                    = 1'b1;
            end else begin
              live_d[i] = live_q[i] + 16'd1;
            end
          end
        end
      end
      KIND_WRITE: begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (tsel == 2'(i)) begin
            if (!in_q.reg_index[0]) begin
              reload_d[i] = in_q.write_data;
            end else begin
              ctrl_d[i].presc   = cpt_presc_e'(wmask[1:0]);
              ctrl_d[i].cascade = wmask[2];
              ctrl_d[i].irq_en  = wmask[6];
              ctrl_d[i].start   = wmask[7];
              // Start edge: restart from reload with a fresh prescaler.
              if (wmask[7] && !ctrl_q[i].start) begin
                live_d[i]  = reload_q[i];
                presc_d[i] = '0;
              end
            end
          end
        end
      end
      KIND_READ: begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (tsel == 2'(i)) begin
            result.read_data = live_q[i];
          end
        end
      end
      default: begin
        result = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.valid && in_ready) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_ready) begin
      in_q <= in_i.payload;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  // State only commits when the registered transaction moves on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        reload_q[i] <= '0;
        live_q[i]   <= '0;
        presc_q[i]  <= '0;
        ctrl_q[i]   <= '0;
      end
    end else if (advance) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        reload_q[i] <= reload_d[i];
        live_q[i]   <= live_d[i];
        presc_q[i]  <= presc_d[i];
        ctrl_q[i]   <= ctrl_d[i];
      end
    end
  end

  // Checks
  logic start_rise0;
  assign start_rise0 = advance && (in_q.kind == KIND_WRITE) && (tsel == 2'd0) &&
                       in_q.reg_index[0] && in_q.write_data[7] && !ctrl_q[0].start;

`include "cascading_prescaled_timers_unit_assert.svh"

  `CPT_ASSERT_IMPL(a_irq_within_ovf, out_valid_q,
                   (out_q.irq_pulse & ~out_q.overflow_pulse) == 4'd0)
  `CPT_ASSERT_NEXT(a_rd_zero_unless_read, advance && (in_q.kind != KIND_READ),
                   out_q.read_data == 16'd0 && out_valid_q)
  `CPT_ASSERT_IMPL(a_stall_only_when_full, !in_ready,
                   in_valid_q && out_valid_q && !out_o.ready)
  `CPT_ASSERT_NEXT(a_start_loads_reload, start_rise0,
                   live_q[0] == $past(reload_q[0]) && presc_q[0] == 10'd0)

endmodule
`default_nettype wire

// ----- tb/cpt_timer_checker.sv -----
// Checker for the cascade timer unit: mirrors the timers, predicts each result and compares.
module cpt_timer_checker
  import cpt_pkg::*;
#(
  parameter int NUM_TIMERS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cpt_chan_if         in_mon,
  cpt_chan_if         out_mon,
  output int          fail_count_o,
  output int unsigned pending_o
);

  logic [15:0] reload_mirror [4];
  logic [15:0] count_mirror  [4];
  cpt_ctrl_t   ctrl_mirror   [4];
  logic [9:0]  presc_mirror  [4];

  cpt_out_t timer_results_due [$];
  int       mismatches = 0;

  function automatic logic [10:0] presc_divide(cpt_presc_e sel);
    logic [10:0] div;
    case (sel)
      PRESC_DIV64:   div = 11'd64;
      PRESC_DIV256:  div = 11'd256;
      PRESC_DIV1024: div = 11'd1024;
      default:       div = 11'd1;
    endcase
    return div;
  endfunction

  // Overflow of timer 'first': reload it and carry into cascaded successors.
  function automatic void ripple_overflow(input int first, inout logic [3:0] irq,
                                          inout logic [3:0] ovf);
    int cur;
    bit done;
    cur  = first;
    done = 1'b0;
    while (!done) begin
      count_mirror[cur] = reload_mirror[cur];
      ovf[cur] = 1'b1;
      if (ctrl_mirror[cur].irq_en) irq[cur] = 1'b1;
      if (cur + 1 >= NUM_TIMERS || cur + 1 >= 4) begin
        done = 1'b1;
      end else if (!ctrl_mirror[cur+1].start || !ctrl_mirror[cur+1].cascade) begin
        done = 1'b1;
      end else if (count_mirror[cur+1] == COUNT_MAX) begin
        cur++;
      end else begin
        count_mirror[cur+1] = count_mirror[cur+1] + 16'd1;
        done = 1'b1;
      end
    end
  endfunction

  function automatic cpt_out_t next_timer_outputs(cpt_in_t item);
    cpt_out_t    res;
    int          tmr;
    logic [10:0] pc;
    logic [15:0] m;
    bit          was_on;
    res = '0;
    tmr = item.reg_index >> 1;
    case (item.kind)
      KIND_TICK: begin
        for (int i = 0; i < NUM_TIMERS && i < 4; i++) begin
          if (ctrl_mirror[i].start && !(i > 0 && ctrl_mirror[i].cascade)) begin
            pc = {1'b0, presc_mirror[i]} + 11'd1;
            if (pc >= presc_divide(ctrl_mirror[i].presc)) begin
              presc_mirror[i] = '0;
              if (count_mirror[i] == COUNT_MAX)
                ripple_overflow(i, res.irq_pulse, res.overflow_pulse);
              else
                count_mirror[i] = count_mirror[i] + 16'd1;
            end else begin
              presc_mirror[i] = pc[9:0];
            end
          end
        end
      end
      KIND_WRITE: begin
        if (tmr < NUM_TIMERS && tmr < 4) begin
          if (!item.reg_index[0]) begin
            reload_mirror[tmr] = item.write_data;
          end else begin
            was_on = ctrl_mirror[tmr].start;
            m = item.write_data & CTL_WRITE_MASK;
            ctrl_mirror[tmr].presc   = cpt_presc_e'(m[1:0]);
            ctrl_mirror[tmr].cascade = m[2];
            ctrl_mirror[tmr].irq_en  = m[6];
            ctrl_mirror[tmr].start   = m[7];
            // only a rising start edge reloads the counter
            if (m[7] && !was_on) begin
              count_mirror[tmr] = reload_mirror[tmr];
              presc_mirror[tmr] = '0;
            end
          end
        end
      end
      KIND_READ: begin
        if (tmr < NUM_TIMERS && tmr < 4) res.read_data = count_mirror[tmr];
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void compare_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cpt_out_t want;
    cpt_out_t got;
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        reload_mirror[i] = '0;
        count_mirror[i]  = '0;
        ctrl_mirror[i]   = '0;
        presc_mirror[i]  = '0;
      end
      timer_results_due.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        timer_results_due.push_back(next_timer_outputs(in_mon.payload));
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.payload;
        if (timer_results_due.size() == 0) begin
          $error("result transaction with nothing expected: 0x%0h", got);
          mismatches++;
        end else begin
          want = timer_results_due.pop_front();
          compare_field("irq_pulse", want.irq_pulse, got.irq_pulse);
          compare_field("overflow_pulse", want.overflow_pulse, got.overflow_pulse);
          compare_field("read_data", want.read_data, got.read_data);
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= timer_results_due.size();
  end

endmodule

// ----- tb/cascading_prescaled_timers_unit_tb.sv -----
// Top of the cascade timer testbench: clock, reset, stimulus, backpressure and verdict.
module cascading_prescaled_timers_unit_tb;
  import cpt_pkg::*;

  localparam int          NUM_TIMERS     = 4;
  localparam int          RANDOM_ITEMS   = 800;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          DRAIN_SLACK    = 20;
  // kind code the block leaves unused; it must produce an all-zero result
  localparam logic [1:0]  KIND_UNUSED    = 2'd3;

  // control register bits as written on the bus
  localparam logic [15:0] CTL_CASCADE    = 16'h0004;
  localparam logic [15:0] CTL_IRQ_EN     = 16'h0040;
  localparam logic [15:0] CTL_START      = 16'h0080;
  localparam logic [15:0] CTL_PRESC      = 16'h0003;

  logic        clk_i;
  logic        rst_ni;
  int          fail_count;
  int unsigned pending;
  int unsigned idle_cycles = 0;

  cpt_chan_if #(.payload_t(cpt_in_t))  in_if ();
  cpt_chan_if #(.payload_t(cpt_out_t)) out_if ();

  cascading_prescaled_timers_unit #(.NUM_TIMERS(NUM_TIMERS)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  cpt_timer_checker #(.NUM_TIMERS(NUM_TIMERS)) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog: any stretch with no transaction on either channel this long is a hang.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side backpressure: a random stall before each transaction, with
  // occasional stretches where ready simply stays high.
  initial begin
    int stall;
    int stretch;
    bit steady;
    stretch = 0;
    steady  = 1'b0;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (stretch == 0) begin
        stretch = $urandom_range(8, 40);
        steady  = ($urandom_range(0, 2) == 0);
      end
      stretch--;
      stall = steady ? 0 : $urandom_range(0, 16);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_if.valid && out_if.ready));
    end
  end

  int send_stretch = 0;
  bit send_steady  = 1'b0;

  // Present one transaction after a random gap and hold it until accepted.
  // valid stays high on return so back-to-back items need no extra edge.
  task automatic send(input logic [1:0] kind, input logic [2:0] idx, input logic [15:0] data);
    int      gap;
    cpt_in_t item;
    item.kind       = kind;
    item.reg_index  = idx;
    item.write_data = data;
    if (send_stretch == 0) begin
      send_stretch = $urandom_range(8, 40);
      send_steady  = ($urandom_range(0, 2) == 0);
    end
    send_stretch--;
    gap = send_steady ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= item;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Hold off the input until the checker has seen every outstanding result.
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    int          sent;
    int unsigned pick;
    logic [15:0] data;
    logic [2:0]  idx;

    rst_ni        <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.payload <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed ---
    // reads straight out of reset, incl. via the control index
    send(KIND_READ, 3'd0, 16'h0000);
    send(KIND_READ, 3'd1, 16'hFFFF);
    send(KIND_UNUSED, 3'd7, 16'hFFFF);
    // reloads: t0 two below wrap, the rest at the top
    send(KIND_WRITE, 3'd0, 16'hFFFE);
    send(KIND_WRITE, 3'd2, 16'hFFFF);
    send(KIND_WRITE, 3'd4, 16'hFFFF);
    send(KIND_WRITE, 3'd6, 16'hFFFF);
    // t3/t2 cascaded with irq, t1 cascaded without irq
    send(KIND_WRITE, 3'd7, CTL_START | CTL_IRQ_EN | CTL_CASCADE);
    send(KIND_WRITE, 3'd5, CTL_START | CTL_IRQ_EN | CTL_CASCADE);
    send(KIND_WRITE, 3'd3, CTL_START | CTL_CASCADE);
    // t0: all bits set -> div 1024, cascade bit must be ignored on timer 0
    send(KIND_WRITE, 3'd1, 16'hFFFF);
    send(KIND_TICK, 3'd0, 16'h0000);
    send(KIND_TICK, 3'd7, 16'hFFFF);
    // drop divisor to 1 with a count pending, no start edge: next tick advances
    send(KIND_WRITE, 3'd1, CTL_START | CTL_IRQ_EN | CTL_CASCADE);
    send(KIND_TICK, 3'd0, 16'h0000);
    // t0 wraps and the carry ripples through all four, last one bumps nothing
    send(KIND_TICK, 3'd0, 16'h0000);
    send(KIND_READ, 3'd2, 16'h0000);
    send(KIND_READ, 3'd5, 16'h0000);
    send(KIND_READ, 3'd6, 16'h0000);
    // only ignored bits set: stops t0
    send(KIND_WRITE, 3'd1, 16'hFF38);
    send(KIND_WRITE, 3'd6, 16'h0000);
    send(KIND_TICK, 3'd0, 16'h0000);
    drain();

    // --- random ---
    // Half the items are ticks, over timers kept busy with reloads near the top, so
    // overflows and cascades show up often; kind 3 is noise and not counted.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      idx  = $urandom_range(0, 7);
      data = $urandom_range(0, 16'hFFFF);
      if (pick < 50) begin
        send(KIND_TICK, idx, data);
        sent++;
      end else if (pick < 62) begin
        send(KIND_READ, idx, data);
        sent++;
      end else if (pick < 72) begin
        if ($urandom_range(0, 1) == 0) data = $urandom_range(16'hFFC0, 16'hFFFF);
        send(KIND_WRITE, {idx[2:1], 1'b0}, data);
        sent++;
      end else if (pick < 88) begin
        if ($urandom_range(0, 9) < 7) data = data | CTL_START;
        if ($urandom_range(0, 9) < 6) data = data & ~CTL_PRESC;
        send(KIND_WRITE, {idx[2:1], 1'b1}, data);
        sent++;
      end else if (pick < 95) begin
        // stop a timer so a later start gives a rising edge again
        send(KIND_WRITE, {idx[2:1], 1'b1}, data & ~CTL_START);
        sent++;
      end else begin
        send(KIND_UNUSED, idx, data);
      end
      if (sent == RANDOM_ITEMS / 2 && pick < 95) drain();
    end

    // wait out everything in flight, then a little longer for strays
    drain();
    repeat (DRAIN_SLACK) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/cpt_pkg.sv
rtl/core/cpt_chan_if.sv
rtl/core/cascading_prescaled_timers_unit.sv
tb/cpt_timer_checker.sv
tb/cascading_prescaled_timers_unit_tb.sv
